// File: design/assert_macros.svh
// Assertion macros shared by the call detector RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define WCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define WCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wcdls_pkg.sv
// Shared types, codes and constants for the windowed call detector and line switch.
// No dependencies; used by wcdls_call_fsm and the top level.
package wcdls_pkg;

  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int RELAY_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LAST    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALL_THRESHOLD = 8'd1;

  // Configuration reset values
  localparam logic [CNT_W-1:0] WINDOW_LAST_RST = 16'd2499;
  localparam logic [CNT_W-1:0] CALL_THRESH_RST = 16'd100;
  localparam logic [CNT_W-1:0] CNT_MAX         = 16'hFFFF;

  // Relay patterns: bit0 plus select, bit1 line 1 minus, bit2 line 2 minus
  localparam logic [RELAY_W-1:0] RELAY_OPEN  = 3'b000;
  localparam logic [RELAY_W-1:0] RELAY_LINE1 = 3'b010;
  localparam logic [RELAY_W-1:0] RELAY_LINE2 = 3'b101;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LINE1 = 2'd1,
    MODE_LINE2 = 2'd2
  } call_mode_t;

  // Per-tick facts handed to the call state machine
  typedef struct packed {
    logic tick;        // a transaction is accepted this cycle
    logic wend;        // this tick is the last of the window
    logic k2;
    logic k3;
    logic line1_zero;
    logic line2_zero;
    logic line1_over;
    logic line2_over;
  } decide_in_t;

  // State after the tick plus the report flags
  typedef struct packed {
    call_mode_t           mode;
    logic [RELAY_W-1:0]   relay;
    logic                 video_one;
    logic                 video_two;
    logic                 report_valid;
    logic                 report_byte;
  } decide_out_t;

  // Increment, holding at the top of the range
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    return r;
  endfunction

endpackage

// File: design/wcdls_call_fsm.sv
// Three-state call machine (idle, line 1, line 2) with relay and video switch state.
// Depends on wcdls_pkg for the mode enum, relay codes and the decide structs.
module wcdls_call_fsm (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wcdls_pkg::decide_in_t    dec_i,
  output wcdls_pkg::decide_out_t   dec_o
);
  import wcdls_pkg::*;

  call_mode_t         mode_r, mode_nxt;
  logic [RELAY_W-1:0] relay_r, relay_nxt;
  logic               video_one_r, video_one_nxt;
  logic               video_two_r, video_two_nxt;
  logic               rep_valid, rep_byte;

  // Hold state unless the window closes on an accepted tick
  always_comb begin
    mode_nxt      = mode_r;
    relay_nxt     = relay_r;
    video_one_nxt = video_one_r;
    video_two_nxt = video_two_r;
    rep_valid     = 1'b0;
    rep_byte      = 1'b0;
    if (dec_i.tick && dec_i.wend) begin
      unique case (mode_r)
        MODE_LINE1: begin
          if (dec_i.line1_zero) begin
            mode_nxt  = MODE_IDLE;
            relay_nxt = RELAY_OPEN;
          end
        end
        MODE_LINE2: begin
          if (dec_i.line2_zero) begin
            mode_nxt      = MODE_IDLE;
            relay_nxt     = RELAY_OPEN;
            video_two_nxt = 1'b0;
          end
        end
        default: begin
          // idle, and the unused code treated the same
          if (dec_i.k2) video_one_nxt = 1'b1;
          if (dec_i.line1_over) begin
            mode_nxt  = MODE_LINE1;
            relay_nxt = RELAY_LINE1;
          end else if (dec_i.line2_over) begin
            mode_nxt  = MODE_LINE2;
            relay_nxt = RELAY_LINE2;
            if (dec_i.k3) begin
              video_one_nxt = 1'b0;
              video_two_nxt = 1'b1;
            end
            rep_valid = 1'b1;
            rep_byte  = dec_i.k3;
          end
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      relay_r     <= RELAY_OPEN;
      video_one_r <= 1'b0;
      video_two_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      relay_r     <= relay_nxt;
      video_one_r <= video_one_nxt;
      video_two_r <= video_two_nxt;
    end
  end

  assign dec_o.mode         = mode_nxt;
  assign dec_o.relay        = relay_nxt;
  assign dec_o.video_one    = video_one_nxt;
  assign dec_o.video_two    = video_two_nxt;
  assign dec_o.report_valid = rep_valid;
  assign dec_o.report_byte  = rep_byte;

endmodule

// File: design/windowed_call_detect_line_switch.sv
// Windowed call detector and line switch. Each input transaction is one sampling
// tick and yields exactly one result transaction, one tick per clock cycle: the
// window and line counters, the threshold compare and the call state machine all
// update in the cycle a tick is accepted, and the result lands in a single output
// register. in_tready stays high while that register is empty or being drained, so
// ticks stream without gaps; a stalled output holds one result and stops input.
// Configuration writes are always ready and take effect on the next tick.
// Depends on wcdls_pkg, wcdls_call_fsm and assert_macros.svh.
`include "assert_macros.svh"

module windowed_call_detect_line_switch (
  input  logic                                clk,
  input  logic                                rst_n,
  // input ticks
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] line1_active, [1] line2_active, [2] jumper_two_set, [3] jumper_three_set
  input  logic [wcdls_pkg::IN_TDATA_W-1:0]    in_tdata,
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] line_switch, [3] video_one_on, [4] video_two_on, [6:5] call_mode,
  // [7] report_valid, [8] report_byte, [9] window_end, [15:10] zero
  output logic [wcdls_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wcdls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcdls_pkg::CNT_W-1:0]         cfg_data
);
  import wcdls_pkg::*;

  logic [CNT_W-1:0] window_last_r, call_thresh_r;
  logic [CNT_W-1:0] win_r, win_nxt;
  logic [CNT_W-1:0] l1_r, l1_nxt, l1_inc;
  logic [CNT_W-1:0] l2_r, l2_nxt, l2_inc;
  logic             wend;
  logic             accept;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  decide_in_t       dec_in;
  decide_out_t      dec_out;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_last_r <= WINDOW_LAST_RST;
      call_thresh_r <= CALL_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_LAST:    window_last_r <= cfg_data;
        CFG_CALL_THRESHOLD: call_thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count active samples, then wrap or advance the window
  always_comb begin
    l1_inc = in_tdata[0] ? sat_inc(l1_r) : l1_r;
    l2_inc = in_tdata[1] ? sat_inc(l2_r) : l2_r;
    if (win_r == window_last_r) begin
      win_nxt = '0;
      l1_nxt  = '0;
      l2_nxt  = '0;
    end else begin
      win_nxt = win_r + 1'b1;
      l1_nxt  = l1_inc;
      l2_nxt  = l2_inc;
    end
    wend = (win_nxt == window_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      l1_r  <= '0;
      l2_r  <= '0;
    end else if (accept) begin
      win_r <= win_nxt;
      l1_r  <= l1_nxt;
      l2_r  <= l2_nxt;
    end
  end

  // Decision facts for the call machine
  assign dec_in.tick       = accept;
  assign dec_in.wend       = wend;
  assign dec_in.k2         = in_tdata[2];
  assign dec_in.k3         = in_tdata[3];
  assign dec_in.line1_zero = (l1_nxt == '0);
  assign dec_in.line2_zero = (l2_nxt == '0);
  assign dec_in.line1_over = (l1_nxt > call_thresh_r);
  assign dec_in.line2_over = (l2_nxt > call_thresh_r);

  wcdls_call_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .dec_i (dec_in),
    .dec_o (dec_out)
  );

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {6'b0, wend, dec_out.report_byte, dec_out.report_valid,
                     dec_out.mode, dec_out.video_two, dec_out.video_one, dec_out.relay};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A report comes only on a window end that enters line 2 mode
  `WCD_ASSERT_SAME(a_report_line2, out_tvalid && out_tdata[7],
    out_tdata[9] && (out_tdata[6:5] == MODE_LINE2), "report without line 2 entry")
  // Relays follow the call mode: a result in line 1 mode carries the line 1 relay pattern
  `WCD_ASSERT_SAME(a_relay_mode, out_tvalid && (out_tdata[6:5] == MODE_LINE1),
    out_tdata[2:0] == RELAY_LINE1, "line 1 mode with wrong relays")
  // A tick at the window's last value restarts the window and the counts
  `WCD_ASSERT_NEXT(a_window_wrap, accept && (win_r == window_last_r),
    (win_r == '0) && (l1_r == '0) && (l2_r == '0), "window did not wrap")

endmodule
